// ===== rtl/core/tpa_pkg.sv =====
// Shared types and constants for the triangle primitive assembler.
package tpa_pkg;

  // Width of every output index and of the offset register.
  localparam int unsigned OutBits = 32;

  // Default width of the raw input indices that the assembler keeps.
  localparam int unsigned IndexBitsDefault = 32;

  // Number of triangles that the queue between front and back can hold.
  localparam int unsigned TriFifoDepth = 4;

  // Configuration register indexes.
  localparam int unsigned CfgIdxBits = 2;
  localparam logic [CfgIdxBits-1:0] CfgFanMode     = 2'd0;
  localparam logic [CfgIdxBits-1:0] CfgIndexOffset = 2'd1;
  localparam logic [CfgIdxBits-1:0] CfgWideOutput  = 2'd2;

  // Mask that wraps an output index at 16 bits.
  localparam logic [OutBits-1:0] NarrowMask = 32'h0000_FFFF;

  // Vertex slot within a triangle, as the back end walks it.
  localparam logic [1:0] SlotFirst  = 2'd0;
  localparam logic [1:0] SlotSecond = 2'd1;
  localparam logic [1:0] SlotThird  = 2'd2;

  // One finished triangle, offsets applied, winding fixed.
  typedef struct packed {
    logic [OutBits-1:0] vert_a;
    logic [OutBits-1:0] vert_b;
    logic [OutBits-1:0] vert_c;
  } tri_t;

  // Fill status of the triangle queue.
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

// ===== rtl/core/tpa_front.sv =====
// Front end: takes indices, tracks strip/fan state and forms offset triangles.
module tpa_front #(
  parameter int unsigned IndexBits = tpa_pkg::IndexBitsDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Index input channel.
  input  logic                               push_i,
  output logic                               full_o,
  input  logic [tpa_pkg::OutBits-1:0]        vertex_index_i,
  input  logic                               list_start_i,
  // Configuration write channel.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [tpa_pkg::CfgIdxBits-1:0]     cfg_index_i,
  input  logic [tpa_pkg::OutBits-1:0]        cfg_data_i,
  // Triangle queue write side.
  output logic                               tri_push_o,
  output tpa_pkg::tri_t                      tri_o,
  input  tpa_pkg::fifo_status_t              fifo_status_i
);

  // Configuration registers.
  logic                        fan_mode_q, fan_mode_d;
  logic [tpa_pkg::OutBits-1:0] index_offset_q, index_offset_d;
  logic                        wide_output_q, wide_output_d;

  // List state.
  logic [IndexBits-1:0] older_vertex_q, older_vertex_d;
  logic [IndexBits-1:0] newer_vertex_q, newer_vertex_d;
  logic [IndexBits-1:0] fan_anchor_q, fan_anchor_d;
  logic [1:0]           seen_count_q, seen_count_d;
  logic                 odd_position_q, odd_position_d;

  // Stage register holding the raw triangle awaiting offset and checks.
  logic                 stg_valid_q, stg_valid_d;
  logic [IndexBits-1:0] stg_a_q, stg_a_d;
  logic [IndexBits-1:0] stg_b_q, stg_b_d;
  logic [IndexBits-1:0] stg_c_q, stg_c_d;
  logic                 stg_swap_q, stg_swap_d;

  logic                 accept;
  logic                 stall;
  logic                 form_tri;
  logic [IndexBits-1:0] vin;
  logic [1:0]           cur_seen;
  logic                 cur_odd;

  logic [tpa_pkg::OutBits-1:0] wrap_mask;
  logic [tpa_pkg::OutBits-1:0] off_a, off_b, off_c;
  logic                        keep;

  assign cfg_ready_o = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_comb begin
    fan_mode_d     = fan_mode_q;
    index_offset_d = index_offset_q;
    wide_output_d  = wide_output_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        tpa_pkg::CfgFanMode:     fan_mode_d     = cfg_data_i[0];
        tpa_pkg::CfgIndexOffset: index_offset_d = cfg_data_i;
        tpa_pkg::CfgWideOutput:  wide_output_d  = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_mode_q     <= 1'b0;
      index_offset_q <= '0;
      wide_output_q  <= 1'b1;
    end else begin
      fan_mode_q     <= fan_mode_d;
      index_offset_q <= index_offset_d;
      wide_output_q  <= wide_output_d;
    end
  end

  // Offset, wrap and the duplicate check on the staged triangle.
  assign wrap_mask = wide_output_q ? '1 : tpa_pkg::NarrowMask;
  assign off_a = (tpa_pkg::OutBits'(stg_a_q) + index_offset_q) & wrap_mask;
  assign off_b = (tpa_pkg::OutBits'(stg_b_q) + index_offset_q) & wrap_mask;
  assign off_c = (tpa_pkg::OutBits'(stg_c_q) + index_offset_q) & wrap_mask;
  assign keep  = (off_a != off_b) && (off_b != off_c) && (off_a != off_c);

  // The stage holds only while a kept triangle waits for queue space.
  assign stall      = stg_valid_q && keep && fifo_status_i.full;
  assign full_o     = stall;
  assign accept     = push_i && !stall;
  assign tri_push_o = stg_valid_q && keep && !fifo_status_i.full;

  // Odd strip triangles swap their first two vertices.
  always_comb begin
    tri_o.vert_c = off_c;
    if (stg_swap_q) begin
      tri_o.vert_a = off_b;
      tri_o.vert_b = off_a;
    end else begin
      tri_o.vert_a = off_a;
      tri_o.vert_b = off_b;
    end
  end

  // List state update and triangle formation for an accepted index.
  assign vin      = vertex_index_i[IndexBits-1:0];
  assign cur_seen = list_start_i ? 2'd0 : seen_count_q;
  assign cur_odd  = list_start_i ? 1'b0 : odd_position_q;
  assign form_tri = accept && (cur_seen == 2'd2);

  always_comb begin
    older_vertex_d = older_vertex_q;
    newer_vertex_d = newer_vertex_q;
    fan_anchor_d   = fan_anchor_q;
    seen_count_d   = seen_count_q;
    odd_position_d = odd_position_q;
    if (accept) begin
      odd_position_d = cur_odd;
      case (cur_seen)
        2'd0: begin
          fan_anchor_d   = vin;
          newer_vertex_d = vin;
          seen_count_d   = 2'd1;
        end
        2'd1: begin
          older_vertex_d = newer_vertex_q;
          newer_vertex_d = vin;
          seen_count_d   = 2'd2;
        end
        default: begin
          odd_position_d = !cur_odd;
          older_vertex_d = newer_vertex_q;
          newer_vertex_d = vin;
          seen_count_d   = 2'd2;
        end
      endcase
    end
  end

  // Stage load: fan is (newer, current, anchor), strip is (older, newer, current).
  always_comb begin
    stg_valid_d = stall;
    stg_a_d     = stg_a_q;
    stg_b_d     = stg_b_q;
    stg_c_d     = stg_c_q;
    stg_swap_d  = stg_swap_q;
    if (form_tri) begin
      stg_valid_d = 1'b1;
      if (fan_mode_q) begin
        stg_a_d    = newer_vertex_q;
        stg_b_d    = vin;
        stg_c_d    = fan_anchor_q;
        stg_swap_d = 1'b0;
      end else begin
        stg_a_d    = older_vertex_q;
        stg_b_d    = newer_vertex_q;
        stg_c_d    = vin;
        stg_swap_d = cur_odd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      older_vertex_q <= '0;
      newer_vertex_q <= '0;
      fan_anchor_q   <= '0;
      seen_count_q   <= 2'd0;
      odd_position_q <= 1'b0;
      stg_valid_q    <= 1'b0;
    end else begin
      older_vertex_q <= older_vertex_d;
      newer_vertex_q <= newer_vertex_d;
      fan_anchor_q   <= fan_anchor_d;
      seen_count_q   <= seen_count_d;
      odd_position_q <= odd_position_d;
      stg_valid_q    <= stg_valid_d;
    end
  end

  // Stage payload needs no reset.
  always_ff @(posedge clk_i) begin
    stg_a_q    <= stg_a_d;
    stg_b_q    <= stg_b_d;
    stg_c_q    <= stg_c_d;
    stg_swap_q <= stg_swap_d;
  end

endmodule

// ===== rtl/core/tpa_fifo.sv =====
// Short triangle queue between the front end and the back end.
module tpa_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tpa_pkg::tri_t         data_i,
  input  logic                  pop_i,
  output tpa_pkg::tri_t         data_o,
  output tpa_pkg::fifo_status_t status_o
);

  localparam int unsigned Depth = tpa_pkg::TriFifoDepth;
  localparam int unsigned PtrW  = $clog2(Depth);

  tpa_pkg::tri_t   mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign status_o.full  = (count_q == (PtrW+1)'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer and fill count bookkeeping.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // The front end never writes into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !status_o.full)
    else $error("triangle pushed into full queue");

  // The fill count never exceeds the depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= (PtrW+1)'(Depth))
    else $error("queue fill count out of range");

  // A lone pop drops the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (do_pop && !do_push) |=> (count_q == $past(count_q) - 1'b1))
    else $error("queue count did not drop after pop");

endmodule

// ===== rtl/core/tpa_back.sv =====
// Back end: walks each queued triangle into three output vertices.
module tpa_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Triangle queue read side.
  input  tpa_pkg::tri_t               tri_i,
  input  tpa_pkg::fifo_status_t       fifo_status_i,
  output logic                        tri_pop_o,
  // Result channel.
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic [tpa_pkg::OutBits-1:0] out_index_o,
  output logic                        triangle_end_o
);

  logic [1:0]                  slot_q, slot_d;
  logic                        out_valid_q, out_valid_d;
  logic [tpa_pkg::OutBits-1:0] out_index_q, out_index_d;
  logic                        out_end_q, out_end_d;
  logic                        load;

  // The output register refills whenever it is free or being taken and the queue is not empty.
  assign load      = !fifo_status_i.empty && (!out_valid_q || pop_i);
  assign tri_pop_o = load && (slot_q == tpa_pkg::SlotThird);

  always_comb begin
    slot_d      = slot_q;
    out_valid_d = out_valid_q && !pop_i;
    out_index_d = out_index_q;
    out_end_d   = out_end_q;
    if (load) begin
      out_valid_d = 1'b1;
      case (slot_q)
        tpa_pkg::SlotFirst: begin
          out_index_d = tri_i.vert_a;
          out_end_d   = 1'b0;
          slot_d      = tpa_pkg::SlotSecond;
        end
        tpa_pkg::SlotSecond: begin
          out_index_d = tri_i.vert_b;
          out_end_d   = 1'b0;
          slot_d      = tpa_pkg::SlotThird;
        end
        default: begin
          out_index_d = tri_i.vert_c;
          out_end_d   = 1'b1;
          slot_d      = tpa_pkg::SlotFirst;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= tpa_pkg::SlotFirst;
      out_valid_q <= 1'b0;
    end else begin
      slot_q      <= slot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_index_q <= out_index_d;
    out_end_q   <= out_end_d;
  end

  assign empty_o        = !out_valid_q;
  assign out_index_o    = out_index_q;
  assign triangle_end_o = out_end_q;

  // The slot counter only takes the three vertex positions.
  assert property (@(posedge clk_i) disable iff (!rst_ni) slot_q != 2'd3)
    else $error("vertex slot out of range");

  // A triangle leaves the queue only as its third vertex is loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   tri_pop_o |=> (out_end_q && slot_q == tpa_pkg::SlotFirst))
    else $error("triangle popped without its closing vertex");

  // A loaded first vertex is never marked as a triangle end.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (load && slot_q == tpa_pkg::SlotFirst) |=> !out_end_q)
    else $error("first vertex marked as triangle end");

endmodule

// ===== rtl/core/triangle_primitive_assembler_core.sv =====
// Top level of the triangle primitive assembler: front end, queue, back end.
//
// Usage: vertex indices enter through a queue-like port (push_i/full_o); an
// index is taken at an edge with push_i high and full_o low. list_start_i
// marks the first index of a new strip or fan. Results leave through
// empty_o/pop_i: while empty_o is low the oldest vertex sits on out_index_o
// and triangle_end_o, and a pop_i at an edge takes it. Registers (fan mode,
// index offset, wide output) are written over cfg_valid_i/cfg_ready_o with
// cfg_index_i and cfg_data_i; the user must write them only while the block
// is idle; the block itself does not enforce it. An index that closes a kept
// triangle passes through the stage register and the queue into the output
// register. Throughput: the output register delivers one vertex per cycle
// while the receiver keeps popping, so a kept triangle occupies the result
// channel for its three vertices; indices that form no triangle, or a
// dropped one, take no room in the queue. A four-triangle queue separates
// the front end from the back end, so input keeps flowing back to back
// until that queue fills while the receiver stalls; full_o then rises. Reset
// clears the list state, the queue and the output register and restores the
// register defaults (strip mode, no offset, 32-bit wrap); then it is ready.
module triangle_primitive_assembler_core #(
  parameter int unsigned IndexBits = tpa_pkg::IndexBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  output logic                           full_o,
  input  logic [tpa_pkg::OutBits-1:0]    vertex_index_i,
  input  logic                           list_start_i,
  output logic                           empty_o,
  input  logic                           pop_i,
  output logic [tpa_pkg::OutBits-1:0]    out_index_o,
  output logic                           triangle_end_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tpa_pkg::CfgIdxBits-1:0] cfg_index_i,
  input  logic [tpa_pkg::OutBits-1:0]    cfg_data_i
);

  logic                  tri_push;
  logic                  tri_pop;
  tpa_pkg::tri_t         tri_in;
  tpa_pkg::tri_t         tri_head;
  tpa_pkg::fifo_status_t fifo_status;

  tpa_front #(
    .IndexBits(IndexBits)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .vertex_index_i (vertex_index_i),
    .list_start_i   (list_start_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .tri_push_o     (tri_push),
    .tri_o          (tri_in),
    .fifo_status_i  (fifo_status)
  );

  tpa_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (tri_push),
    .data_i   (tri_in),
    .pop_i    (tri_pop),
    .data_o   (tri_head),
    .status_o (fifo_status)
  );

  tpa_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .tri_i          (tri_head),
    .fifo_status_i  (fifo_status),
    .tri_pop_o      (tri_pop),
    .empty_o        (empty_o),
    .pop_i          (pop_i),
    .out_index_o    (out_index_o),
    .triangle_end_o (triangle_end_o)
  );

endmodule
